>>> rtl/core/prs_pkg.sv
package prs_pkg;

   // field widths
   localparam int unsigned DELAY_W     = 16;
   localparam int unsigned RAIL_W      = 7;
   localparam int unsigned FAIL_W      = 3;
   localparam int unsigned REQ_W       = 2;
   localparam int unsigned CSR_INDEX_W = 2;

   // request codes
   typedef logic [REQ_W-1:0] req_code_type;
   localparam req_code_type REQ_TICK  = 2'd0;
   localparam req_code_type REQ_START = 2'd1;
   localparam req_code_type REQ_DOWN  = 2'd2;

   // control register indexes
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_SHORT_DELAY = 2'd0;
   localparam csr_index_type CSR_RAIL_DELAY  = 2'd1;
   localparam csr_index_type CSR_AUX_CHECK   = 2'd2;

   // control register reset values
   localparam logic [DELAY_W-1:0] SHORT_DELAY_RESET = 16'd10;
   localparam logic [DELAY_W-1:0] RAIL_DELAY_RESET  = 16'd100;

   // failure codes
   typedef logic [FAIL_W-1:0] fail_code_type;
   localparam fail_code_type FAIL_NONE  = 3'd0;
   localparam fail_code_type FAIL_VDD   = 3'd1;
   localparam fail_code_type FAIL_VLL   = 3'd2;
   localparam fail_code_type FAIL_VDRAM = 3'd3;
   localparam fail_code_type FAIL_VL    = 3'd4;
   localparam fail_code_type FAIL_VCORE = 3'd5;
   localparam fail_code_type FAIL_AUX   = 3'd6;
   localparam fail_code_type FAIL_VCC   = 3'd7;

   // rail bit positions in power_good and rail_enable
   localparam int unsigned RAIL_VDD   = 0;
   localparam int unsigned RAIL_VLL   = 1;
   localparam int unsigned RAIL_VDRAM = 2;
   localparam int unsigned RAIL_VL    = 3;
   localparam int unsigned RAIL_VCORE = 4;
   localparam int unsigned RAIL_AUX   = 5;
   localparam int unsigned RAIL_VCC   = 6;

   // sequencer steps
   typedef enum logic [3:0] {
      STEP_OFF,
      STEP_RST,
      STEP_CLKOFF,
      STEP_VDD,
      STEP_VLL,
      STEP_VDRAM,
      STEP_VL,
      STEP_VCORE,
      STEP_CLKON,
      STEP_AUX,
      STEP_VCC,
      STEP_DONE
   } step_type;

   typedef struct packed {
      logic [REQ_W-1:0]  req_type;
      logic [RAIL_W-1:0] power_good;
   } prs_req_type;

   typedef struct packed {
      logic [RAIL_W-1:0] rail_enable;
      logic              core_clock_on;
      logic              driver_reset;
      logic              sequencing;
      logic              powered_up;
      logic [FAIL_W-1:0] fail_step;
   } prs_rsp_type;

   typedef struct packed {
      logic [DELAY_W-1:0] short_delay_ticks;
      logic [DELAY_W-1:0] rail_delay_ticks;
      logic               aux_check_enable;
   } prs_cfg_type;

   // step that follows a finished wait; anything unexpected powers down
   function automatic step_type step_after(step_type s);
      step_type n;
      n = STEP_OFF;
      case (s)
         STEP_RST:    n = STEP_CLKOFF;
         STEP_CLKOFF: n = STEP_VDD;
         STEP_VDD:    n = STEP_VLL;
         STEP_VLL:    n = STEP_VDRAM;
         STEP_VDRAM:  n = STEP_VL;
         STEP_VL:     n = STEP_VCORE;
         STEP_VCORE:  n = STEP_CLKON;
         STEP_CLKON:  n = STEP_AUX;
         STEP_AUX:    n = STEP_VCC;
         STEP_VCC:    n = STEP_DONE;
         default:     n = STEP_OFF;
      endcase
      return n;
   endfunction

endpackage

>>> rtl/core/power_rail_sequencer.sv
// Power rail sequencer.
// Request channel (req_*): each transaction is a tick, a start request or a
// power-down request, carrying the sampled power-good bits. Every request
// transaction yields exactly one response transaction (rsp_*) that shows the
// rail enables, core clock, driver reset and sequence status after it.
// Control channel (csr_*): index 0 short delay, 1 rail delay, 2 aux check
// enable; always ready, write it only while no transaction is in flight.
// Pipeline: a request is registered on acceptance and its response is
// registered from it once the response register is free or being taken.
// Throughput: one transaction per cycle while the response side does not
// stall, set by the state update between the request and response registers.
// Stall: when rsp_ready is low the response holds; the request register
// still takes one more transaction, after which req_ready drops until the
// response is taken.
// Reset: rails off, core clock stopped, drivers held in reset, no failure,
// delays back to 10 and 100 ticks, aux check off, both stages empty.
module power_rail_sequencer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  prs_pkg::prs_req_type         req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output prs_pkg::prs_rsp_type         rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  prs_pkg::csr_index_type       csr_index,
   input  logic [prs_pkg::DELAY_W-1:0]  csr_data
);

   logic                  req_valid_ff, req_valid_in;
   prs_pkg::prs_req_type  req_data_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   prs_pkg::prs_rsp_type  rsp_data_ff;
   prs_pkg::prs_rsp_type  next_result;
   prs_pkg::prs_cfg_type  cfg;
   logic                  advance;

   prs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   prs_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .update      (advance),
      .item        (req_data_ff),
      .cfg         (cfg),
      .next_result (next_result)
   );

   // held transaction moves on when the response slot is free
   assign advance      = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !req_valid_ff || advance;
   assign req_valid_in = (req_valid && req_ready) || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   // handshake flags
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= next_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/core/prs_csr.sv
module prs_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  prs_pkg::csr_index_type       csr_index,
   input  logic [prs_pkg::DELAY_W-1:0]  csr_data,
   output prs_pkg::prs_cfg_type         cfg
);

   prs_pkg::prs_cfg_type cfg_ff, cfg_in;

   // register writes are always taken
   assign csr_ready = 1'b1;

   // write decode, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            prs_pkg::CSR_SHORT_DELAY: cfg_in.short_delay_ticks = csr_data;
            prs_pkg::CSR_RAIL_DELAY:  cfg_in.rail_delay_ticks  = csr_data;
            prs_pkg::CSR_AUX_CHECK:   cfg_in.aux_check_enable  = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_delay_ticks <= prs_pkg::SHORT_DELAY_RESET;
         cfg_ff.rail_delay_ticks  <= prs_pkg::RAIL_DELAY_RESET;
         cfg_ff.aux_check_enable  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/prs_seq.sv
module prs_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  update,
   input  prs_pkg::prs_req_type  item,
   input  prs_pkg::prs_cfg_type  cfg,
   output prs_pkg::prs_rsp_type  next_result
);

   prs_pkg::step_type                  step_ff, step_in;
   logic [prs_pkg::DELAY_W-1:0]        wait_ff, wait_in;
   logic [prs_pkg::RAIL_W-1:0]         enables_ff, enables_in;
   logic                               clock_on_ff, clock_on_in;
   logic                               reset_held_ff, reset_held_in;
   prs_pkg::fail_code_type             failure_ff, failure_in;

   logic                               busy;
   logic                               is_tick;
   logic                               wait_done;
   logic                               check_ok;
   prs_pkg::fail_code_type             check_code;
   logic [prs_pkg::RAIL_W-1:0]         pg;

   assign pg        = item.power_good;
   assign busy      = (step_ff != prs_pkg::STEP_OFF) && (step_ff != prs_pkg::STEP_DONE);
   assign is_tick   = (item.req_type == prs_pkg::REQ_TICK);
   assign wait_done = is_tick && busy && (wait_ff <= 16'd1);

   // power-good check made when the current wait ends
   always_comb begin
      check_ok   = 1'b1;
      check_code = prs_pkg::FAIL_NONE;
      unique case (step_ff)
         prs_pkg::STEP_VDD: begin
            check_ok   = pg[prs_pkg::RAIL_VDD];
            check_code = prs_pkg::FAIL_VDD;
         end
         prs_pkg::STEP_VLL: begin
            check_ok   = pg[prs_pkg::RAIL_VLL];
            check_code = prs_pkg::FAIL_VLL;
         end
         prs_pkg::STEP_VDRAM: begin
            check_ok   = pg[prs_pkg::RAIL_VDRAM];
            check_code = prs_pkg::FAIL_VDRAM;
         end
         prs_pkg::STEP_VL: begin
            check_ok   = pg[prs_pkg::RAIL_VL];
            check_code = prs_pkg::FAIL_VL;
         end
         prs_pkg::STEP_VCORE: begin
            check_ok   = pg[prs_pkg::RAIL_VCORE];
            check_code = prs_pkg::FAIL_VCORE;
         end
         prs_pkg::STEP_AUX: begin
            check_ok   = !cfg.aux_check_enable || pg[prs_pkg::RAIL_AUX];
            check_code = prs_pkg::FAIL_AUX;
         end
         prs_pkg::STEP_VCC: begin
            check_ok   = pg[prs_pkg::RAIL_VCC];
            check_code = prs_pkg::FAIL_VCC;
         end
         default: ;
      endcase
   end

   // next step
   always_comb begin
      step_in = step_ff;
      if (update) begin
         unique case (item.req_type)
            prs_pkg::REQ_DOWN: step_in = prs_pkg::STEP_OFF;
            prs_pkg::REQ_START: begin
               if (step_ff == prs_pkg::STEP_OFF) step_in = prs_pkg::STEP_RST;
            end
            prs_pkg::REQ_TICK: begin
               if (wait_done) begin
                  step_in = check_ok ? prs_pkg::step_after(step_ff) : prs_pkg::STEP_OFF;
               end
            end
            default: ;
         endcase
      end
   end

   // rail, clock, reset, counter and failure updates
   always_comb begin
      wait_in       = wait_ff;
      enables_in    = enables_ff;
      clock_on_in   = clock_on_ff;
      reset_held_in = reset_held_ff;
      failure_in    = failure_ff;
      if (update) begin
         unique case (item.req_type)
            prs_pkg::REQ_DOWN: begin
               wait_in       = '0;
               enables_in    = '0;
               clock_on_in   = 1'b0;
               reset_held_in = 1'b1;
            end
            prs_pkg::REQ_START: begin
               if (step_ff == prs_pkg::STEP_OFF) begin
                  failure_in    = prs_pkg::FAIL_NONE;
                  enables_in    = '0;
                  clock_on_in   = 1'b0;
                  reset_held_in = 1'b1;
                  wait_in       = cfg.short_delay_ticks;
               end
            end
            prs_pkg::REQ_TICK: begin
               if (busy && !wait_done) begin
                  wait_in = wait_ff - 16'd1;
               end else if (wait_done && !check_ok) begin
                  // failed check drops everything and records the step
                  failure_in    = check_code;
                  wait_in       = '0;
                  enables_in    = '0;
                  clock_on_in   = 1'b0;
                  reset_held_in = 1'b1;
               end else if (wait_done) begin
                  wait_in = cfg.rail_delay_ticks;
                  unique case (step_ff)
                     prs_pkg::STEP_RST: begin
                        clock_on_in = 1'b0;
                        wait_in     = cfg.short_delay_ticks;
                     end
                     prs_pkg::STEP_CLKOFF: enables_in[prs_pkg::RAIL_VDD]   = 1'b1;
                     prs_pkg::STEP_VDD:    enables_in[prs_pkg::RAIL_VLL]   = 1'b1;
                     prs_pkg::STEP_VLL:    enables_in[prs_pkg::RAIL_VDRAM] = 1'b1;
                     prs_pkg::STEP_VDRAM:  enables_in[prs_pkg::RAIL_VL]    = 1'b1;
                     prs_pkg::STEP_VL:     enables_in[prs_pkg::RAIL_VCORE] = 1'b1;
                     prs_pkg::STEP_VCORE:  clock_on_in = 1'b1;
                     prs_pkg::STEP_CLKON:  enables_in[prs_pkg::RAIL_AUX]   = 1'b1;
                     prs_pkg::STEP_AUX:    enables_in[prs_pkg::RAIL_VCC]   = 1'b1;
                     prs_pkg::STEP_VCC: begin
                        reset_held_in = 1'b0;
                        wait_in       = '0;
                     end
                     default: begin
                        wait_in       = '0;
                        enables_in    = '0;
                        clock_on_in   = 1'b0;
                        reset_held_in = 1'b1;
                     end
                  endcase
               end
            end
            default: ;
         endcase
      end
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= prs_pkg::STEP_OFF;
         wait_ff       <= '0;
         enables_ff    <= '0;
         clock_on_ff   <= 1'b0;
         reset_held_ff <= 1'b1;
         failure_ff    <= prs_pkg::FAIL_NONE;
      end else begin
         step_ff       <= step_in;
         wait_ff       <= wait_in;
         enables_ff    <= enables_in;
         clock_on_ff   <= clock_on_in;
         reset_held_ff <= reset_held_in;
         failure_ff    <= failure_in;
      end
   end

   // result shows the state after this transaction
   always_comb begin
      next_result.rail_enable   = enables_in;
      next_result.core_clock_on = clock_on_in;
      next_result.driver_reset  = reset_held_in;
      next_result.sequencing    = (step_in != prs_pkg::STEP_OFF) &&
                                  (step_in != prs_pkg::STEP_DONE);
      next_result.powered_up    = (step_in == prs_pkg::STEP_DONE);
      next_result.fail_step     = failure_in;
   end

endmodule

>>> rtl/core/prs_checker.sv
module prs_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  prs_pkg::prs_rsp_type  rsp_data
);

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // no response out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a completed power-up has every rail, the clock and drivers running
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.powered_up |->
         !rsp_data.sequencing && rsp_data.rail_enable == 7'h7f &&
         rsp_data.core_clock_on && !rsp_data.driver_reset)
      else $error("powered up with outputs not all on");

   // powered off means everything dropped
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.sequencing && !rsp_data.powered_up |->
         rsp_data.rail_enable == 7'h00 && !rsp_data.core_clock_on &&
         rsp_data.driver_reset)
      else $error("idle with outputs still on");

   // an accepted request while the response side is ready is followed by a valid response
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && rsp_ready |=> ##1 rsp_valid)
      else $error("missing response");

endmodule

bind power_rail_sequencer prs_checker u_prs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import prs_pkg::*;

   // request and register codes the package leaves unnamed
   localparam req_code_type  REQ_UNUSED = 2'd3;
   localparam csr_index_type CSR_UNUSED = 2'd3;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned SHOWN_ERRORS = 10;

   // statuses that can be read straight off the sequence
   localparam prs_rsp_type RSP_IDLE = '{rail_enable: 7'h00, core_clock_on: 1'b0,
      driver_reset: 1'b1, sequencing: 1'b0, powered_up: 1'b0, fail_step: FAIL_NONE};
   localparam prs_rsp_type RSP_STARTING = '{rail_enable: 7'h00, core_clock_on: 1'b0,
      driver_reset: 1'b1, sequencing: 1'b1, powered_up: 1'b0, fail_step: FAIL_NONE};
   localparam prs_rsp_type RSP_UP = '{rail_enable: 7'h7F, core_clock_on: 1'b1,
      driver_reset: 1'b0, sequencing: 1'b0, powered_up: 1'b1, fail_step: FAIL_NONE};
   localparam prs_rsp_type RSP_VDD_FAILED = '{rail_enable: 7'h00, core_clock_on: 1'b0,
      driver_reset: 1'b1, sequencing: 1'b0, powered_up: 1'b0, fail_step: FAIL_VDD};

   typedef struct {
      prs_req_type item;
      bit          typed;
      prs_rsp_type want;
   } vector_row_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   prs_req_type         req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   prs_rsp_type         rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   csr_index_type       csr_index = CSR_SHORT_DELAY;
   logic [DELAY_W-1:0]  csr_data = '0;

   power_rail_sequencer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // predicted sequencer state and settings
   step_type           seq_step  = STEP_OFF;
   logic [DELAY_W-1:0] wait_left = '0;
   logic [RAIL_W-1:0]  rails_on  = '0;
   logic               clk_on    = 1'b0;
   logic               drv_rst   = 1'b1;
   fail_code_type      fail_code = FAIL_NONE;
   logic [DELAY_W-1:0] cfg_short = SHORT_DELAY_RESET;
   logic [DELAY_W-1:0] cfg_rail  = RAIL_DELAY_RESET;
   logic               cfg_aux   = 1'b0;

   prs_rsp_type    pending_status[$];
   vector_row_type directed_rows[$];
   int unsigned mismatches    = 0;
   int unsigned status_count  = 0;
   int unsigned send_idle_pct = 13;
   int unsigned recv_idle_pct = 45;
   int unsigned cycle_count   = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: FAIL");
      $finish;
   end

   // everything off, failure code kept
   function automatic void shut_down();
      rails_on  = '0;
      clk_on    = 1'b0;
      drv_rst   = 1'b1;
      wait_left = '0;
      seq_step  = STEP_OFF;
   endfunction

   // end of a wait: either abort with code or turn on the next rail
   function automatic void check_rail(input logic ok, input fail_code_type code,
                                      input int unsigned next_rail,
                                      input step_type next_step);
      if (!ok) begin
         fail_code = code;
         shut_down();
      end else begin
         rails_on[next_rail] = 1'b1;
         seq_step  = next_step;
         wait_left = cfg_rail;
      end
   endfunction

   // one request through the sequencer, status after the update
   function automatic prs_rsp_type advance_sequencer(input prs_req_type item);
      prs_rsp_type       outcome;
      logic [RAIL_W-1:0] pg;
      pg = item.power_good;
      case (item.req_type)
         REQ_DOWN: shut_down();
         REQ_START: begin
            if (seq_step == STEP_OFF) begin
               fail_code = FAIL_NONE;
               rails_on  = '0;
               clk_on    = 1'b0;
               drv_rst   = 1'b1;
               seq_step  = STEP_RST;
               wait_left = cfg_short;
            end
         end
         REQ_TICK: begin
            if (seq_step >= STEP_RST && seq_step <= STEP_VCC) begin
               if (wait_left > 1) begin
                  wait_left = wait_left - 1'b1;
               end else begin
                  case (seq_step)
                     STEP_RST: begin
                        clk_on    = 1'b0;
                        seq_step  = STEP_CLKOFF;
                        wait_left = cfg_short;
                     end
                     STEP_CLKOFF: check_rail(1'b1, FAIL_NONE, RAIL_VDD, STEP_VDD);
                     STEP_VDD:    check_rail(pg[RAIL_VDD], FAIL_VDD, RAIL_VLL, STEP_VLL);
                     STEP_VLL:    check_rail(pg[RAIL_VLL], FAIL_VLL, RAIL_VDRAM, STEP_VDRAM);
                     STEP_VDRAM:  check_rail(pg[RAIL_VDRAM], FAIL_VDRAM, RAIL_VL, STEP_VL);
                     STEP_VL:     check_rail(pg[RAIL_VL], FAIL_VL, RAIL_VCORE, STEP_VCORE);
                     STEP_VCORE: begin
                        if (!pg[RAIL_VCORE]) begin
                           fail_code = FAIL_VCORE;
                           shut_down();
                        end else begin
                           clk_on    = 1'b1;
                           seq_step  = STEP_CLKON;
                           wait_left = cfg_rail;
                        end
                     end
                     STEP_CLKON: check_rail(1'b1, FAIL_NONE, RAIL_AUX, STEP_AUX);
                     STEP_AUX: begin
                        check_rail(!cfg_aux || pg[RAIL_AUX], FAIL_AUX, RAIL_VCC, STEP_VCC);
                     end
                     STEP_VCC: begin
                        if (!pg[RAIL_VCC]) begin
                           fail_code = FAIL_VCC;
                           shut_down();
                        end else begin
                           drv_rst   = 1'b0;
                           wait_left = '0;
                           seq_step  = STEP_DONE;
                        end
                     end
                     default: shut_down();
                  endcase
               end
            end else if (seq_step != STEP_OFF && seq_step != STEP_DONE) begin
               shut_down();
            end
         end
         default: ;
      endcase
      outcome.rail_enable   = rails_on;
      outcome.core_clock_on = clk_on;
      outcome.driver_reset  = drv_rst;
      outcome.sequencing    = (seq_step >= STEP_RST && seq_step <= STEP_VCC);
      outcome.powered_up    = (seq_step == STEP_DONE);
      outcome.fail_step     = fail_code;
      return outcome;
   endfunction

   // mostly well-formed power-up runs, with glitches on power good and some noise
   function automatic prs_req_type pick_request();
      prs_req_type r;
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 3)
         r.req_type = REQ_DOWN;
      else if (roll < 5)
         r.req_type = REQ_UNUSED;
      else if (roll < 8 || (seq_step == STEP_OFF && roll < 70))
         r.req_type = REQ_START;
      else
         r.req_type = REQ_TICK;
      r.power_good = 7'h7F;
      roll = $urandom_range(99);
      if (roll < 6)
         r.power_good = RAIL_W'($urandom_range(127));
      else if (roll < 12)
         r.power_good[$urandom_range(RAIL_W - 1)] = 1'b0;
      return r;
   endfunction

   function automatic void add_vector(input req_code_type code, input logic [RAIL_W-1:0] pg,
                                      input bit typed, input prs_rsp_type want);
      vector_row_type row;
      row.item.req_type   = code;
      row.item.power_good = pg;
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endfunction

   // present one request, hold until accepted, then log its predicted status
   task automatic send_item(input prs_req_type item, input bit typed,
                            input prs_rsp_type want);
      prs_rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = advance_sequencer(item);
      pending_status.push_back(typed ? want : predicted);
   endtask

   // stop sending and let every outstanding status come back
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type index, input logic [DELAY_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_SHORT_DELAY: cfg_short = value;
         CSR_RAIL_DELAY:  cfg_rail  = value;
         CSR_AUX_CHECK:   cfg_aux   = value[0];
         default: ;
      endcase
   endtask

   // full register set, plus a write to the unused index
   task automatic set_registers(input logic [DELAY_W-1:0] short_ticks,
                                input logic [DELAY_W-1:0] rail_ticks, input logic aux);
      logic [DELAY_W-1:0] aux_word;
      aux_word    = DELAY_W'($urandom_range(65535));
      aux_word[0] = aux;
      write_csr(CSR_SHORT_DELAY, short_ticks);
      write_csr(CSR_RAIL_DELAY, rail_ticks);
      write_csr(CSR_AUX_CHECK, aux_word);
      write_csr(CSR_UNUSED, DELAY_W'($urandom_range(65535)));
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(input int unsigned items, input int unsigned send_pct,
                             input int unsigned recv_pct, input bit hold_midway);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int unsigned n = 0; n < items; n++) begin
         if (hold_midway && n == items / 2)
            drain();
         send_item(pick_request(), 1'b0, RSP_IDLE);
      end
      drain();
   endtask

   // response side stalls
   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // compare each response transaction with the oldest prediction
   always @(posedge clock) begin : status_check
      prs_rsp_type want;
      bit          bad;
      if (!reset && rsp_valid && rsp_ready) begin
         status_count++;
         if (pending_status.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOWN_ERRORS)
               $display("%0t: unexpected response %0d: %h", $realtime, status_count, rsp_data);
         end else begin
            want = pending_status.pop_front();
            bad  = (rsp_data.rail_enable   !== want.rail_enable)   ||
                   (rsp_data.core_clock_on !== want.core_clock_on) ||
                   (rsp_data.driver_reset  !== want.driver_reset)  ||
                   (rsp_data.sequencing    !== want.sequencing)    ||
                   (rsp_data.powered_up    !== want.powered_up)    ||
                   (rsp_data.fail_step     !== want.fail_step);
            if (bad) begin
               mismatches++;
               if (mismatches <= SHOWN_ERRORS)
                  $display({"%0t: response %0d mismatch: expected rails=%h clk=%b rst=%b ",
                            "seq=%b up=%b fail=%0d, got rails=%h clk=%b rst=%b seq=%b up=%b ",
                            "fail=%0d"}, $realtime, status_count,
                           want.rail_enable, want.core_clock_on, want.driver_reset,
                           want.sequencing, want.powered_up, want.fail_step,
                           rsp_data.rail_enable, rsp_data.core_clock_on,
                           rsp_data.driver_reset, rsp_data.sequencing,
                           rsp_data.powered_up, rsp_data.fail_step);
            end
         end
      end
   end

   // stimulus
   initial begin
      // reset state, ignored requests, one clean power-up with minimum waits,
      // then a vdd failure that survives power-down and is cleared by start
      add_vector(REQ_TICK,   7'h00, 1'b1, RSP_IDLE);
      add_vector(REQ_UNUSED, 7'h7F, 1'b1, RSP_IDLE);
      add_vector(REQ_DOWN,   7'h00, 1'b1, RSP_IDLE);
      add_vector(REQ_START,  7'h7F, 1'b1, RSP_STARTING);
      add_vector(REQ_START,  7'h00, 1'b0, RSP_IDLE);
      for (int k = 0; k < 9; k++)
         add_vector(REQ_TICK, 7'h7F, 1'b0, RSP_IDLE);
      add_vector(REQ_TICK,   7'h7F, 1'b1, RSP_UP);
      add_vector(REQ_TICK,   7'h00, 1'b0, RSP_IDLE);
      add_vector(REQ_START,  7'h00, 1'b0, RSP_IDLE);
      add_vector(REQ_UNUSED, 7'h00, 1'b0, RSP_IDLE);
      add_vector(REQ_DOWN,   7'h00, 1'b1, RSP_IDLE);
      add_vector(REQ_START,  7'h00, 1'b1, RSP_STARTING);
      add_vector(REQ_TICK,   7'h00, 1'b0, RSP_IDLE);
      add_vector(REQ_TICK,   7'h00, 1'b0, RSP_IDLE);
      add_vector(REQ_TICK,   7'h00, 1'b1, RSP_VDD_FAILED);
      add_vector(REQ_DOWN,   7'h00, 1'b1, RSP_VDD_FAILED);
      add_vector(REQ_START,  7'h7F, 1'b1, RSP_STARTING);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // zero delays act as a single tick
      set_registers(16'd0, 16'd0, 1'b1);
      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      drain();

      set_registers(16'd1, 16'd2, 1'b0);
      run_random(300, 13, 45, 1'b1);
      set_registers(16'd0, 16'd1, 1'b1);
      run_random(300, 45, 13, 1'b0);
      set_registers(16'd2, 16'd0, 1'b1);
      run_random(180, 0, 0, 1'b0);
      // largest delays: long countdowns from the top of the counter
      set_registers(16'hFFFF, 16'd3, 1'b0);
      run_random(60, 0, 0, 1'b0);
      set_registers(16'd1, 16'hFFFF, 1'b1);
      run_random(60, 0, 0, 1'b0);

      if (mismatches == 0 && pending_status.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
